// ===== rtl/fixed_pool_free_stack_allocator_assert.svh =====
// assertion macros for the pool allocator rtl
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef FIXED_POOL_FREE_STACK_ALLOCATOR_ASSERT_SVH
`define FIXED_POOL_FREE_STACK_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FPFSA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpfsa assertion failed");

`define FPFSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpfsa implication failed");

`define FPFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpfsa next-cycle check failed");

`else

`define FPFSA_ASSERT(label, prop)
`define FPFSA_ASSERT_IMPL(label, ante, cons)
`define FPFSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/fpfsa_pkg.sv =====
// shared types and codes for the fixed pool free stack allocator
// no dependencies
package fpfsa_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_SIZE  = 3'd2,
    STAT_RANGE = 3'd3,
    STAT_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_BASE     = 2'd0,
    CFG_ELEMENT_SIZE  = 2'd1,
    CFG_ELEMENT_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_USED
  } state_e;

  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [31:0] ResetPoolBase = 32'd0;
  localparam logic [15:0] ResetElementSize = 16'd64;
  localparam logic [8:0] ResetElementCount = 9'd256;

  typedef struct packed {
    action_e     action;
    logic [31:0] address;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] granted_address;
    logic [8:0]  free_elements;
    logic [23:0] used_bytes;
  } rsp_t;

endpackage

// ===== rtl/fpfsa_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
module fpfsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fixed_pool_free_stack_allocator.sv =====
// top level of the fixed-size pool allocator with a lifo free stack
// depends on fpfsa_pkg, fpfsa_ram and fixed_pool_free_stack_allocator_assert.svh
//
// usage
//   a request (allocate, free, clear) is taken when start is high and busy is
//   low. exactly one response follows: after the exec and used states done_o
//   rises and stays high for one cycle with rsp_o valid. busy stays high
//   through the exec and used states, so a new request is not taken before the
//   previous one is through; it can be taken in the same cycle that the
//   previous response is shown. the steps of a request are stack ram read, pop
//   or push decision, then the bytes-in-use multiply before the response
//   register.
//   configuration (pool base, element size, element count) must be written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i only while idle; the block itself
//   does not enforce this. a new configuration does not touch the stack until the next clear.
//   at reset the stack reads as full with base + i * size; no clearing pass is
//   run, untouched entries below a low-water mark are computed instead of read
//   from the ram, so requests are taken right after reset.
//   the receiver cannot stall; every response must be taken when done_o is high.
module fixed_pool_free_stack_allocator #(
  parameter int unsigned MAX_ELEMENTS = 256,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  fpfsa_pkg::req_t                      req_i,
  output logic                                 done_o,
  output fpfsa_pkg::rsp_t                      rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [fpfsa_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [fpfsa_pkg::CfgWidth-1:0]       cfg_wdata_i
);

`include "fixed_pool_free_stack_allocator_assert.svh"

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned MW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned ResetDepth = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;

  fpfsa_pkg::state_e state_q, state_d;
  fpfsa_pkg::req_t   req_q, req_d;
  fpfsa_pkg::rsp_t   rsp_q, rsp_d;
  fpfsa_pkg::status_e status_q, status_d;

  logic              done_q, done_d;
  logic [CW-1:0]     depth_q, depth_d;
  logic [CW-1:0]     mark_q, mark_d;
  logic [MW-1:0]     fill_base_q, fill_base_d;
  logic [15:0]       fill_size_q, fill_size_d;
  logic [IW+15:0]    fill_prod_q, fill_prod_d;
  logic              fill_hit_q, fill_hit_d;
  logic [CW+15:0]    span_q, span_d;
  logic [MW-1:0]     granted_q, granted_d;

  logic [31:0]       cfg_base_q;
  logic [15:0]       cfg_size_q;
  logic [8:0]        cfg_count_q;

  logic [CW-1:0]     n_eff;
  logic [IW-1:0]     rd_idx;
  logic              mem_re, mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [MW-1:0]     mem_wdata, mem_rdata;
  logic [31:0]       addr_off;
  logic              in_range;
  logic [CW-1:0]     used_cnt;
  logic [CW+15:0]    used_prod;

  assign n_eff = (32'(cfg_count_q) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(cfg_count_q);
  assign rd_idx = IW'(depth_q - CW'(1));
  assign addr_off = req_q.address - cfg_base_q;
  assign in_range = (req_q.address >= cfg_base_q) && (48'(addr_off) < 48'(span_q));
  assign used_cnt = (depth_q < n_eff) ? (n_eff - depth_q) : '0;
  assign used_prod = used_cnt * cfg_size_q;

  assign busy = (state_q != fpfsa_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    status_d    = status_q;
    done_d      = 1'b0;
    depth_d     = depth_q;
    mark_d      = mark_q;
    fill_base_d = fill_base_q;
    fill_size_d = fill_size_q;
    fill_prod_d = fill_prod_q;
    fill_hit_d  = fill_hit_q;
    span_d      = span_q;
    granted_d   = granted_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = IW'(depth_q);
    mem_wdata   = MW'(req_q.address);
    case (state_q)
      fpfsa_pkg::ST_IDLE: begin
        if (start) begin
          req_d       = req_i;
          mem_re      = 1'b1;
          span_d      = n_eff * cfg_size_q;
          fill_prod_d = rd_idx * fill_size_q;
          fill_hit_d  = (depth_q <= mark_q);
          state_d     = fpfsa_pkg::ST_EXEC;
        end
      end
      fpfsa_pkg::ST_EXEC: begin
        status_d  = fpfsa_pkg::STAT_OK;
        granted_d = '0;
        case (req_q.action)
          fpfsa_pkg::ACT_ALLOC: begin
            if (req_q.request_size > cfg_size_q) begin
              status_d = fpfsa_pkg::STAT_SIZE;
            end else if (depth_q == '0) begin
              status_d = fpfsa_pkg::STAT_EMPTY;
            end else begin
              depth_d = depth_q - CW'(1);
              if (fill_hit_q) begin
                granted_d = fill_base_q + MW'(fill_prod_q);
                mark_d    = depth_q - CW'(1);
              end else begin
                granted_d = mem_rdata;
              end
            end
          end
          fpfsa_pkg::ACT_FREE: begin
            if (!in_range) begin
              status_d = fpfsa_pkg::STAT_RANGE;
            end else if ((depth_q >= n_eff) || (32'(depth_q) >= MAX_ELEMENTS)) begin
              status_d = fpfsa_pkg::STAT_FULL;
            end else begin
              mem_we  = 1'b1;
              depth_d = depth_q + CW'(1);
            end
          end
          fpfsa_pkg::ACT_CLEAR: begin
            depth_d     = n_eff;
            mark_d      = n_eff;
            fill_base_d = MW'(cfg_base_q);
            fill_size_d = cfg_size_q;
          end
          default: begin
          end
        endcase
        state_d = fpfsa_pkg::ST_USED;
      end
      fpfsa_pkg::ST_USED: begin
        rsp_d.status          = status_q;
        rsp_d.granted_address = 32'(granted_q);
        rsp_d.free_elements   = 9'(depth_q);
        rsp_d.used_bytes      = 24'(used_prod);
        done_d                = 1'b1;
        state_d               = fpfsa_pkg::ST_IDLE;
      end
      default: begin
        state_d = fpfsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpfsa_pkg::ST_IDLE;
      done_q      <= 1'b0;
      depth_q     <= CW'(ResetDepth);
      mark_q      <= CW'(ResetDepth);
      fill_base_q <= MW'(fpfsa_pkg::ResetPoolBase);
      fill_size_q <= fpfsa_pkg::ResetElementSize;
      cfg_base_q  <= fpfsa_pkg::ResetPoolBase;
      cfg_size_q  <= fpfsa_pkg::ResetElementSize;
      cfg_count_q <= fpfsa_pkg::ResetElementCount;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      depth_q     <= depth_d;
      mark_q      <= mark_d;
      fill_base_q <= fill_base_d;
      fill_size_q <= fill_size_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fpfsa_pkg::CFG_POOL_BASE:     cfg_base_q  <= cfg_wdata_i;
          fpfsa_pkg::CFG_ELEMENT_SIZE:  cfg_size_q  <= cfg_wdata_i[15:0];
          fpfsa_pkg::CFG_ELEMENT_COUNT: cfg_count_q <= cfg_wdata_i[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rsp_q       <= rsp_d;
    status_q    <= status_d;
    fill_prod_q <= fill_prod_d;
    fill_hit_q  <= fill_hit_d;
    span_q      <= span_d;
    granted_q   <= granted_d;
  end

  fpfsa_ram #(
    .Width (MW),
    .Depth (MAX_ELEMENTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx),
    .rdata_o (mem_rdata)
  );

  // stack bookkeeping
  `FPFSA_ASSERT(a_depth_cap, 32'(depth_q) <= MAX_ELEMENTS)
  `FPFSA_ASSERT(a_mark_below_depth, mark_q <= depth_q)
  // sequencing
  `FPFSA_ASSERT_NEXT(a_accept_exec, start && !busy, state_q == fpfsa_pkg::ST_EXEC)
  `FPFSA_ASSERT_IMPL(a_done_after_used, done_q, $past(state_q) == fpfsa_pkg::ST_USED)
  `FPFSA_ASSERT_IMPL(a_write_in_exec, mem_we, state_q == fpfsa_pkg::ST_EXEC)

endmodule
